// ===== hdl/lpht_pkg.sv =====
// lpht_pkg: shared types, sizes and codes of the linear probing hash table
// no dependencies; imported by every module of the block but lpht_ram
package lpht_pkg;

  // table geometry (table size must be a power of two: home slot is a mask)
  localparam int TABLE_SIZE = 16;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int STAT_W     = 3;
  localparam int WORD_W     = KEY_W + VAL_W;

  // request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // slot state codes
  localparam logic [1:0] SS_EMPTY   = 2'd0;
  localparam logic [1:0] SS_USED    = 2'd1;
  localparam logic [1:0] SS_DELETED = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] RES_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] RES_UPDATED   = 3'd1;
  localparam logic [STAT_W-1:0] RES_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] RES_REMOVED   = 3'd3;
  localparam logic [STAT_W-1:0] RES_NOT_FOUND = 3'd4;

  // classified request as it leaves the front queue
  typedef struct packed {
    logic                    kind;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
    logic [SLOT_W-1:0]       home;
  } req_t;

  // one result item
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } res_t;

  // probe engine states
  typedef enum logic [3:0] {
    PS_IDLE  = 4'b0001,
    PS_READ  = 4'b0010,
    PS_CHECK = 4'b0100,
    PS_DONE  = 4'b1000
  } probe_state_t;

endpackage

// ===== hdl/lpht_ram.sv =====
// lpht_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ===== hdl/lpht_front.sv =====
// lpht_front: two entry request queue that works out each key's home slot
// depends on lpht_pkg
module lpht_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_kind,
  input  logic [lpht_pkg::KEY_W-1:0]    in_key,
  input  logic signed [lpht_pkg::VAL_W-1:0] in_value,
  output lpht_pkg::req_t                req,
  output logic                          req_valid,
  input  logic                          req_pop
);
  import lpht_pkg::*;

  req_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;
  req_t       cls;

  // classify: home slot is the key masked to the table size
  always_comb begin
    cls.kind  = in_kind;
    cls.key   = in_key;
    cls.value = in_value;
    cls.home  = in_key[SLOT_W-1:0];
  end

  assign full      = (cnt_r == 2'd2);
  assign req_valid = (cnt_r != 2'd0);
  assign req       = ent_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = req_pop && req_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== hdl/lpht_out_q.sv =====
// lpht_out_q: two entry result queue between the probe engine and the result ports
// depends on lpht_pkg
module lpht_out_q (
  input  logic           clk,
  input  logic           rst_n,
  input  lpht_pkg::res_t res,
  input  logic           res_push,
  output logic           res_full,
  output lpht_pkg::res_t out_res,
  output logic           empty,
  input  logic           pop
);
  import lpht_pkg::*;

  res_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign res_full = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign out_res  = ent_r[rd_ptr_r];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= res;
    end
  end

endmodule

// ===== hdl/lpht_probe.sv =====
// lpht_probe: probe engine; slot states in flops, keys and values in a ram
// depends on lpht_pkg and lpht_ram
module lpht_probe (
  input  logic           clk,
  input  logic           rst_n,
  input  lpht_pkg::req_t req,
  input  logic           req_valid,
  output logic           req_pop,
  output lpht_pkg::res_t res,
  output logic           res_push,
  input  logic           res_full
);
  import lpht_pkg::*;

  probe_state_t      state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  res_t              res_r, res_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [1:0]        slot_state_r [TABLE_SIZE];

  logic              ss_we;
  logic [1:0]        ss_val;
  logic [1:0]        cur_st;
  logic [SLOT_W-1:0] ptr_inc;
  logic              wrap;
  logic              key_hit;
  logic              ram_we, ram_re;
  logic [WORD_W-1:0] rd_word;

  // key and value store
  lpht_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_SIZE)
  ) u_kv_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ptr_r),
    .wr_data ({req_r.value, req_r.key}),
    .rd_en   (ram_re),
    .rd_addr (ptr_r),
    .rd_data (rd_word)
  );

  // probe step helpers
  assign cur_st  = slot_state_r[ptr_r];
  assign key_hit = (rd_word[KEY_W-1:0] == req_r.key);
  assign ptr_inc = (ptr_r == SLOT_W'(TABLE_SIZE - 1)) ? '0 : ptr_r + 1'b1;
  assign wrap    = (ptr_inc == req_r.home);
  assign res      = res_r;
  assign res_push = (state_r == PS_DONE);

  // sequencer: read key, compare, then step, write or finish
  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    ptr_nxt   = ptr_r;
    res_nxt   = res_r;
    count_nxt = count_r;
    req_pop   = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ss_we     = 1'b0;
    ss_val    = SS_USED;
    case (state_r)
      PS_IDLE: begin
        if (req_valid) begin
          req_pop   = 1'b1;
          req_nxt   = req;
          ptr_nxt   = req.home;
          state_nxt = PS_READ;
        end
      end
      PS_READ: begin
        ram_re    = 1'b1;
        state_nxt = PS_CHECK;
      end
      PS_CHECK: begin
        state_nxt      = PS_DONE;
        res_nxt.slot   = ptr_r;
        if (req_r.kind == REQ_INSERT) begin
          if (cur_st == SS_USED) begin
            if (key_hit) begin
              ram_we         = 1'b1;
              res_nxt.status = RES_UPDATED;
            end else if (wrap) begin
              res_nxt.status = RES_FULL;
              res_nxt.slot   = '0;
            end else begin
              ptr_nxt   = ptr_inc;
              state_nxt = PS_READ;
            end
          end else begin
            // free or deleted slot: fill it
            ram_we         = 1'b1;
            ss_we          = 1'b1;
            ss_val         = SS_USED;
            count_nxt      = count_r + 1'b1;
            res_nxt.status = RES_INSERTED;
          end
        end else begin
          if (cur_st == SS_EMPTY) begin
            res_nxt.status = RES_NOT_FOUND;
            res_nxt.slot   = '0;
          end else if (cur_st == SS_USED && key_hit) begin
            ss_we          = 1'b1;
            ss_val         = SS_DELETED;
            count_nxt      = (count_r != '0) ? count_r - 1'b1 : count_r;
            res_nxt.status = RES_REMOVED;
          end else if (wrap) begin
            res_nxt.status = RES_NOT_FOUND;
            res_nxt.slot   = '0;
          end else begin
            ptr_nxt   = ptr_inc;
            state_nxt = PS_READ;
          end
        end
        res_nxt.count = count_nxt;
      end
      PS_DONE: begin
        if (!res_full) begin
          state_nxt = PS_IDLE;
        end
      end
      default: begin
        state_nxt = PS_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    ptr_r <= ptr_nxt;
    res_r <= res_nxt;
  end

  // slot states, cleared to never used at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        slot_state_r[i] <= SS_EMPTY;
      end
    end else if (ss_we) begin
      slot_state_r[ptr_r] <= ss_val;
    end
  end

  // live count never goes past the table size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_SIZE))
    else $error("live count beyond table size");

  // a fresh insert leaves its slot occupied
  a_insert_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PS_DONE && res_r.status == RES_INSERTED)
      |-> slot_state_r[res_r.slot] == SS_USED)
    else $error("inserted slot not marked occupied");

  // full and not found report slot zero
  a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PS_DONE &&
     (res_r.status == RES_FULL || res_r.status == RES_NOT_FOUND))
      |-> res_r.slot == '0)
    else $error("miss result with nonzero slot");

  // a result is only offered after a compare step or while it waits
  a_done_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == PS_DONE) |-> $past(state_r) == PS_CHECK)
    else $error("result stage entered without a compare");

endmodule

// ===== hdl/linear_probe_hash_table.sv =====
// Open addressing hash table of 16 slots with linear probing and tombstones.
// A request is an insert (update on key match, fill the first free or deleted
// slot, full after one lap) or a remove (skip tombstones, stop at a never used
// slot or after one lap). Both sides look like queues: push/full for requests
// and empty/pop for results, with two entry queues on either side. Each probe
// step is a key ram read state followed by a compare state that does any write,
// and a request also passes the idle and done states of the engine; it probes
// from 1 to 16 slots. The single read port of the key ram sets this split.
// No clearing pass is needed after reset.
// depends on lpht_pkg, lpht_front, lpht_probe, lpht_out_q, lpht_ram
module linear_probe_hash_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_req_type,
  input  logic [lpht_pkg::KEY_W-1:0]         in_req_key,
  input  logic signed [lpht_pkg::VAL_W-1:0]  in_req_value,
  output logic                               empty,
  input  logic                               pop,
  output logic [lpht_pkg::STAT_W-1:0]        out_status,
  output logic [lpht_pkg::SLOT_W-1:0]        out_slot_index,
  output logic [lpht_pkg::CNT_W-1:0]         out_live_count
);
  import lpht_pkg::*;

  req_t req;
  logic req_valid, req_pop;
  res_t res, out_res;
  logic res_push, res_full;

  // front: request transfer and classification
  lpht_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_kind   (in_req_type),
    .in_key    (in_req_key),
    .in_value  (in_req_value),
    .req       (req),
    .req_valid (req_valid),
    .req_pop   (req_pop)
  );

  // back: probing and table update
  lpht_probe u_probe (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_valid (req_valid),
    .req_pop   (req_pop),
    .res       (res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  // result queue
  lpht_out_q u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .res_push (res_push),
    .res_full (res_full),
    .out_res  (out_res),
    .empty    (empty),
    .pop      (pop)
  );

  assign out_status     = out_res.status;
  assign out_slot_index = out_res.slot;
  assign out_live_count = out_res.count;

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for linear_probe_hash_table, queue handshakes on both sides
// depends on lpht_pkg and the linear_probe_hash_table rtl; holds its own model of the slots
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lpht_pkg::*;

  localparam int QUIET_TAIL   = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE    = 24;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 250;

  typedef struct {
    logic                    kind;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } hash_req_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    push = 1'b0;
  logic                    pop = 1'b0;
  logic                    in_req_type = REQ_INSERT;
  logic [KEY_W-1:0]        in_req_key = '0;
  logic signed [VAL_W-1:0] in_req_value = '0;
  logic                    full;
  logic                    empty;
  logic [STAT_W-1:0]       out_status;
  logic [SLOT_W-1:0]       out_slot_index;
  logic [CNT_W-1:0]        out_live_count;

  // model of the slot array
  logic [1:0]       slot_st [TABLE_SIZE];
  logic [KEY_W-1:0] slot_k  [TABLE_SIZE];
  logic [VAL_W-1:0] slot_v  [TABLE_SIZE];
  logic [CNT_W-1:0] live_entries;

  hash_req_t pending_reqs[$];
  res_t      expected_answers[$];
  hash_req_t next_req;
  res_t      want;
  int        total_items = 0;
  int        sent_count = 0;
  int        recv_count = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        fail_count = 0;
  int        quiet_cycles = 0;

  linear_probe_hash_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_req_type    (in_req_type),
    .in_req_key     (in_req_key),
    .in_req_value   (in_req_value),
    .empty          (empty),
    .pop            (pop),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_live_count (out_live_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // insert probes while occupied, remove probes until a never used slot; one lap at most
  function automatic res_t apply_request(input logic kind, input logic [KEY_W-1:0] key,
                                         input logic [VAL_W-1:0] value);
    res_t             r;
    logic [SLOT_W-1:0] s;
    bit               settled;
    r.status = (kind == REQ_INSERT) ? RES_FULL : RES_NOT_FOUND;
    r.slot   = '0;
    s        = SLOT_W'(key % TABLE_SIZE);
    settled  = 1'b0;
    for (int n = 0; n < TABLE_SIZE && !settled; n++) begin
      if (kind == REQ_INSERT) begin
        if (slot_st[s] != SS_USED) begin
          slot_st[s]   = SS_USED;
          slot_k[s]    = key;
          slot_v[s]    = value;
          live_entries = live_entries + 1'b1;
          r.status     = RES_INSERTED;
          r.slot       = s;
          settled      = 1'b1;
        end else if (slot_k[s] == key) begin
          slot_v[s] = value;
          r.status  = RES_UPDATED;
          r.slot    = s;
          settled   = 1'b1;
        end
      end else begin
        if (slot_st[s] == SS_EMPTY) begin
          settled = 1'b1;
        end else if (slot_st[s] == SS_USED && slot_k[s] == key) begin
          slot_st[s] = SS_DELETED;
          if (live_entries != 0) live_entries = live_entries - 1'b1;
          r.status = RES_REMOVED;
          r.slot   = s;
          settled  = 1'b1;
        end
      end
      s = s + 1'b1;
    end
    r.count = live_entries;
    return r;
  endfunction

  // random idling is off in every third stretch and over the tail of the run
  function automatic bit idle_ok(input int done_n);
    return (done_n < total_items - QUIET_TAIL) && ((done_n / 120) % 3 != 2);
  endfunction

  // keys whose home slots crowd around one base, so probe chains grow long
  function automatic logic [KEY_W-1:0] clustered_key(input int base);
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom);
    k[SLOT_W-1:0] = SLOT_W'((base + $urandom_range(0, 5)) % TABLE_SIZE);
    return k;
  endfunction

  task automatic add_req(input logic kind, input logic [KEY_W-1:0] key,
                         input logic signed [VAL_W-1:0] value);
    hash_req_t r;
    r.kind  = kind;
    r.key   = key;
    r.value = value;
    pending_reqs.push_back(r);
  endtask

  task automatic report_fail(input string msg);
    fail_count++;
    $display("%s", msg);
  endtask

  // request side: predict on each transfer, then pick what to offer next
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      in_gap = 0;
      for (int i = 0; i < TABLE_SIZE; i++) slot_st[i] = SS_EMPTY;
      live_entries = '0;
    end else begin
      if (push && !full) begin
        expected_answers.push_back(apply_request(in_req_type, in_req_key, in_req_value));
        sent_count++;
      end
      if (!push || !full) begin
        if (in_gap > 0) begin
          in_gap--;
          push <= 1'b0;
        end else if (idle_ok(sent_count) && $urandom_range(0, 4) == 0) begin
          in_gap = $urandom_range(0, 3);
          push <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          in_req_type  <= next_req.kind;
          in_req_key   <= next_req.key;
          in_req_value <= next_req.value;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result side: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      out_gap = 0;
    end else begin
      if (pop && !empty) begin
        recv_count++;
        if (expected_answers.size() == 0) begin
          report_fail($sformatf("%0t: unexpected result status %0d slot %0d count %0d",
                                $time, out_status, out_slot_index, out_live_count));
        end else begin
          want = expected_answers.pop_front();
          if (out_status !== want.status)
            report_fail($sformatf("%0t: status expected %0d actual %0d",
                                  $time, want.status, out_status));
          if (out_slot_index !== want.slot)
            report_fail($sformatf("%0t: slot_index expected %0d actual %0d",
                                  $time, want.slot, out_slot_index));
          if (out_live_count !== want.count)
            report_fail($sformatf("%0t: live_count expected %0d actual %0d",
                                  $time, want.count, out_live_count));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        pop <= 1'b0;
      end else if (idle_ok(recv_count) && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 3);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               insert_pct [PHASES];
    int               base;
    insert_pct = '{80, 60, 35, 75, 25, 55};

    // directed: empty table, collisions, tombstones, duplicates, full table
    add_req(REQ_REMOVE, 31'd5, 32'sd7);
    add_req(REQ_INSERT, 31'd0, 32'sh8000_0000);
    add_req(REQ_INSERT, 31'd16, 32'sh7FFF_FFFF);
    add_req(REQ_INSERT, 31'd32, 32'sd0);
    add_req(REQ_INSERT, 31'd16, -32'sd1);
    add_req(REQ_REMOVE, 31'd16, 32'sh7FFF_FFFF);
    // key 32 gets a second copy in the tombstone ahead of the first
    add_req(REQ_INSERT, 31'd32, 32'sd5);
    add_req(REQ_REMOVE, 31'd32, 32'sh8000_0000);
    add_req(REQ_REMOVE, 31'd32, -32'sd1);
    // miss that walks past both tombstones to a never used slot
    add_req(REQ_REMOVE, 31'd48, 32'sd0);
    add_req(REQ_INSERT, 31'h7FFF_FFFF, 32'sh5555_5555);
    for (int i = 1; i <= 14; i++) add_req(REQ_INSERT, 31'h2AAA_AAA0 | KEY_W'(i), $urandom);
    add_req(REQ_INSERT, 31'h5555_5553, 32'sd9);
    add_req(REQ_INSERT, 31'd0, 32'sd42);
    add_req(REQ_REMOVE, 31'h1555_5557, 32'sd3);

    // random phases: a slowly changing key pool, insert share moving up and down
    for (int p = 0; p < PHASES; p++) begin
      base = $urandom_range(0, TABLE_SIZE - 1);
      if (p == 0) begin
        for (int j = 0; j < POOL_SIZE; j++) key_pool[j] = clustered_key(base);
      end else begin
        for (int j = 0; j < 8; j++)
          key_pool[$urandom_range(0, POOL_SIZE - 1)] = clustered_key(base);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 8)
          add_req($urandom_range(0, 1) ? REQ_REMOVE : REQ_INSERT, KEY_W'($urandom),
                  $urandom);
        else
          add_req(($urandom_range(0, 99) < insert_pct[p]) ? REQ_INSERT : REQ_REMOVE,
                  key_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom);
      end
    end
    total_items = pending_reqs.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || push || expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lpht_pkg.sv
hdl/lpht_ram.sv
hdl/lpht_front.sv
hdl/lpht_out_q.sv
hdl/lpht_probe.sv
hdl/linear_probe_hash_table.sv
bench/tb_top.sv
